// ===== rtl/core/rsca_pkg.sv =====
package rsca_pkg;

    localparam int TAG_W = 13;
    localparam int CFG_MIN_BYTES = 1024;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_FRAME  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE  = 2'd1;
    localparam logic [1:0] ST_NOT_CACHED = 2'd2;

    localparam logic [TAG_W-1:0] TAG_FREE = '0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] owner;
        logic [18:0] request_bytes;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] block_offset;
        logic        wrapped_now;
        logic        thrashing;
    } t_out;

endpackage

// ===== rtl/core/rsca_ram.sv =====
module rsca_ram #(
    parameter int AW = 4,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== rtl/core/rover_surface_cache_allocator.sv =====
// Channel  | Signals                        | Direction
// request  | i_in_valid, o_in_stall, i_in   | in
// result   | o_out_valid, i_out_stall, o_out| out
// config   | i_cfg_we, i_cfg_data           | in
//
// One request at a time. An allocation reads the block header memory again for each
// absorbed block and checks the owner memory for each owned block it evicts.
// Reset and flush sweep the owner memory, one entry a cycle over min(OWNER_COUNT, 4096)
// entries, while requests are stalled.
// A result waits in the output register while the next request is taken.
module rover_surface_cache_allocator #(
    parameter int CACHE_BYTES     = 262144,
    parameter int HEADER_BYTES    = 64,
    parameter int OWNER_COUNT     = 4096,
    parameter int SPLIT_THRESHOLD = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rsca_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rsca_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [18:0]     i_cfg_data
);
    import rsca_pkg::*;

    localparam int WORDS       = CACHE_BYTES / 4;
    localparam int AW          = $clog2(WORDS);
    localparam int WW          = $clog2(WORDS + 1);
    localparam int ODEPTH      = (OWNER_COUNT < 4096) ? OWNER_COUNT : 4096;
    localparam int OIW         = $clog2(ODEPTH);
    localparam int SPLIT_WORDS = SPLIT_THRESHOLD / 4;
    localparam int DEF_BYTES   = (CACHE_BYTES < 262144) ? CACHE_BYTES : 262144;
    localparam int DEF_WORDS   = DEF_BYTES / 4;
    localparam int BW          = WW + TAG_W;
    localparam int OW          = 1 + AW;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_CLR      = 12'b0000_0000_0010,
        S_RD_BASE  = 12'b0000_0000_0100,
        S_EV_RD    = 12'b0000_0000_1000,
        S_EV_CHK   = 12'b0000_0001_0000,
        S_MERGE    = 12'b0000_0010_0000,
        S_MERGE_RD = 12'b0000_0100_0000,
        S_WB_FRAG  = 12'b0000_1000_0000,
        S_WB_BASE  = 12'b0001_0000_0000,
        S_FLAGS    = 12'b0010_0000_0000,
        S_LK_RD    = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    t_state           r_state;
    logic [OIW-1:0]   r_cnt;
    logic             r_clr_rsp;
    logic [WW-1:0]    r_cfg_words;
    logic [WW-1:0]    r_active;
    logic [WW-1:0]    r_rover;
    logic             r_rover_null;
    logic [WW-1:0]    r_init;
    logic             r_init_null;
    logic             r_wrapped;
    logic             r_thrash;
    logic             r_wrap_now;
    logic [WW-1:0]    r_sw;
    logic [AW-1:0]    r_base;
    logic [WW-1:0]    r_size;
    logic [TAG_W-1:0] r_tag;
    logic [AW-1:0]    r_ev_word;
    logic [11:0]      r_owner;
    t_out             r_res;

    logic             blk_we, blk_re, own_we, own_re;
    logic [AW-1:0]    blk_waddr, blk_raddr;
    logic [BW-1:0]    blk_wdata, blk_rdata;
    logic [OIW-1:0]   own_waddr, own_raddr;
    logic [OW-1:0]    own_wdata, own_rdata;

    logic             in_acc, out_load;
    logic [31:0]      sw32, lim32, nxt32, left32, frag32, cfg32;
    logic             too_big, rover_reset, owner_ok, split, ev_hit, th_set;
    logic [TAG_W-1:0] tag_new;
    logic [OIW-1:0]   ev_idx;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_DONE) && (!o_out_valid || !i_out_stall);

    assign sw32        = (32'(HEADER_BYTES) + 32'(i_in.request_bytes) + 32'd3) >> 2;
    assign too_big     = sw32 > 32'(r_active);
    assign lim32       = 32'(r_active) - sw32;
    assign rover_reset = r_rover_null || (32'(r_rover) > lim32);
    assign nxt32       = 32'(r_base) + 32'(r_size);
    assign left32      = (r_size >= r_sw) ? 32'(r_size - r_sw) : 32'd0;
    assign split       = left32 > 32'(SPLIT_WORDS);
    assign frag32      = 32'(r_base) + 32'(r_sw);
    assign owner_ok    = 32'(r_owner) < 32'(OWNER_COUNT);
    assign tag_new     = owner_ok ? TAG_W'(13'(r_owner) + 13'd1) : TAG_FREE;
    assign ev_idx      = OIW'(r_tag - TAG_W'(1));
    assign ev_hit      = own_rdata[OW-1] && (own_rdata[AW-1:0] == r_ev_word);
    assign th_set      = r_wrap_now ||
                         (!r_rover_null && (r_init_null || r_rover >= r_init));

    always_comb begin
        cfg32 = 32'(i_cfg_data);
        if (cfg32 < 32'(CFG_MIN_BYTES)) begin
            cfg32 = 32'(CFG_MIN_BYTES);
        end
        if (cfg32 > 32'(CACHE_BYTES)) begin
            cfg32 = 32'(CACHE_BYTES);
        end
    end

    always_comb begin
        blk_we    = 1'b0;
        blk_waddr = r_base;
        blk_wdata = {r_size, tag_new};
        blk_re    = 1'b0;
        blk_raddr = rover_reset ? '0 : r_rover[AW-1:0];
        own_we    = 1'b0;
        own_waddr = r_cnt;
        own_wdata = '0;
        own_re    = 1'b0;
        own_raddr = i_in.owner[OIW-1:0];
        unique case (r_state)
            S_IDLE: begin
                blk_re = in_acc && (i_in.mode == MODE_ALLOC) && !too_big;
                own_re = in_acc && (i_in.mode == MODE_LOOKUP);
            end
            S_CLR: begin
                own_we = 1'b1;
                if (r_cnt == '0) begin
                    blk_we    = 1'b1;
                    blk_waddr = '0;
                    blk_wdata = {r_active, TAG_FREE};
                end
            end
            S_EV_RD: begin
                own_re    = (r_tag != TAG_FREE);
                own_raddr = ev_idx;
            end
            S_EV_CHK: begin
                own_we    = ev_hit;
                own_waddr = ev_idx;
            end
            S_MERGE: begin
                blk_raddr = nxt32[AW-1:0];
                blk_re    = (r_size < r_sw) && (nxt32 < 32'(r_active));
            end
            S_WB_FRAG: begin
                blk_we    = split;
                blk_waddr = frag32[AW-1:0];
                blk_wdata = {left32[WW-1:0], TAG_FREE};
            end
            S_WB_BASE: begin
                blk_we    = 1'b1;
                own_we    = owner_ok;
                own_waddr = r_owner[OIW-1:0];
                own_wdata = {1'b1, r_base};
            end
            default: begin
            end
        endcase
    end

    rsca_ram #(.AW(AW), .DW(BW)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (blk_we),
        .i_waddr (blk_waddr),
        .i_wdata (blk_wdata),
        .i_re    (blk_re),
        .i_raddr (blk_raddr),
        .o_rdata (blk_rdata)
    );

    rsca_ram #(.AW(OIW), .DW(OW)) u_own_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_re    (own_re),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_cnt        <= '0;
            r_clr_rsp    <= 1'b0;
            r_cfg_words  <= WW'(DEF_WORDS);
            r_active     <= WW'(DEF_WORDS);
            r_rover      <= '0;
            r_rover_null <= 1'b0;
            r_init       <= '0;
            r_init_null  <= 1'b0;
            r_wrapped    <= 1'b0;
            r_thrash     <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_words <= cfg32[WW+1:2];
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_owner <= i_in.owner;
                    r_sw    <= sw32[WW-1:0];
                    if (in_acc) begin
                        unique case (i_in.mode)
                            MODE_ALLOC: begin
                                if (too_big) begin
                                    r_res   <= '{ST_TOO_LARGE, 18'd0, 1'b0, r_thrash};
                                    r_state <= S_DONE;
                                end else begin
                                    r_wrap_now <= !r_rover_null && rover_reset;
                                    r_base     <= rover_reset ? '0 : r_rover[AW-1:0];
                                    if (rover_reset) begin
                                        r_rover      <= '0;
                                        r_rover_null <= 1'b0;
                                    end
                                    r_state <= S_RD_BASE;
                                end
                            end
                            MODE_LOOKUP: begin
                                r_state <= S_LK_RD;
                            end
                            MODE_FLUSH: begin
                                r_active     <= r_cfg_words;
                                r_rover      <= '0;
                                r_rover_null <= 1'b0;
                                r_cnt        <= '0;
                                r_clr_rsp    <= 1'b1;
                                r_state      <= S_CLR;
                            end
                            MODE_FRAME: begin
                                r_init      <= r_rover;
                                r_init_null <= r_rover_null;
                                r_wrapped   <= 1'b0;
                                r_thrash    <= 1'b0;
                                r_res       <= '{ST_OK, 18'd0, 1'b0, 1'b0};
                                r_state     <= S_DONE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_cnt <= r_cnt + OIW'(1);
                    if (32'(r_cnt) == 32'(ODEPTH - 1)) begin
                        r_res   <= '{ST_OK, 18'd0, 1'b0, r_thrash};
                        r_state <= r_clr_rsp ? S_DONE : S_IDLE;
                    end
                end
                S_RD_BASE: begin
                    r_size    <= blk_rdata[BW-1:TAG_W];
                    r_tag     <= blk_rdata[TAG_W-1:0];
                    r_ev_word <= r_base;
                    r_state   <= S_EV_RD;
                end
                S_EV_RD: begin
                    r_state <= (r_tag != TAG_FREE) ? S_EV_CHK : S_MERGE;
                end
                S_EV_CHK: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    r_ev_word <= nxt32[AW-1:0];
                    r_state   <= blk_re ? S_MERGE_RD : S_WB_FRAG;
                end
                S_MERGE_RD: begin
                    r_size  <= r_size + blk_rdata[BW-1:TAG_W];
                    r_tag   <= blk_rdata[TAG_W-1:0];
                    r_state <= S_EV_RD;
                end
                S_WB_FRAG: begin
                    if (split) begin
                        r_rover      <= frag32[WW-1:0];
                        r_rover_null <= 1'b0;
                        r_size       <= r_sw;
                    end else if (nxt32 >= 32'(r_active)) begin
                        r_rover      <= '0;
                        r_rover_null <= 1'b1;
                    end else begin
                        r_rover <= nxt32[WW-1:0];
                    end
                    r_state <= S_WB_BASE;
                end
                S_WB_BASE: begin
                    r_state <= S_FLAGS;
                end
                S_FLAGS: begin
                    // Once wrapped, reaching the frame's starting rover again means thrash.
                    if (r_wrapped) begin
                        if (th_set) begin
                            r_thrash <= 1'b1;
                        end
                    end else if (r_wrap_now) begin
                        r_wrapped <= 1'b1;
                    end
                    r_res <= '{ST_OK, 18'((32'(r_base) << 2)), r_wrap_now,
                               r_thrash || (r_wrapped && th_set)};
                    r_state <= S_DONE;
                end
                S_LK_RD: begin
                    if (owner_ok && own_rdata[OW-1]) begin
                        r_res <= '{ST_OK, 18'((32'(own_rdata[AW-1:0]) << 2)), 1'b0,
                                   r_thrash};
                    end else begin
                        r_res <= '{ST_NOT_CACHED, 18'd0, 1'b0, r_thrash};
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out <= r_res;
        end
    end

    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during clearing sweep");

    a_rover_in_cache: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rover_null |-> (r_rover < r_active))
        else $error("rover outside active cache");

    a_no_wrap_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != ST_OK)) |-> !o_out.wrapped_now)
        else $error("wrap reported on failed request");
endmodule

// ===== test/rover_surface_cache_allocator_tb.sv =====
`timescale 1ns / 100ps

module rover_surface_cache_allocator_tb;
    import rsca_pkg::*;

    localparam int WORDS_MAX  = 262144 / 4;
    localparam int OWNERS     = 4096;
    localparam int HDR_BYTES  = 64;
    localparam int SPLIT_MIN  = 256;
    localparam int IDLE_LIMIT = 300000;

    typedef struct {
        t_in  req;
        bit   typed;
        t_out want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic [18:0] i_cfg_data = '0;

    rover_surface_cache_allocator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Mirror of the allocator state.
    int unsigned size_words[WORDS_MAX];
    int unsigned owner_tag[WORDS_MAX];
    int unsigned owner_word[OWNERS];
    bit          owner_held[OWNERS];
    int unsigned cfg_bytes, live_words, rover, first_rover;
    bit          rover_at_end, first_at_end, wrapped_flag, thrash_flag;

    t_out pending_results[$];
    int   errors = 0;
    int   send_gap_pct = 0;
    int   stall_pct = 0;
    int   hold_cycles = 0;
    int   quiet_cycles = 0;

    function automatic void drop_owner(int unsigned w);
        int unsigned o;
        if (owner_tag[w] != 0) begin
            o = owner_tag[w] - 1;
            if (o < OWNERS && owner_held[o] && owner_word[o] == w)
                owner_held[o] = 1'b0;
        end
        owner_tag[w] = 0;
    endfunction

    function automatic void reset_cache();
        foreach (owner_held[i]) owner_held[i] = 1'b0;
        live_words = cfg_bytes >> 2;
        size_words[0] = live_words;
        owner_tag[0] = 0;
        rover = 0;
        rover_at_end = 1'b0;
    endfunction

    function automatic void set_cache_bytes(int unsigned v);
        if (v < CFG_MIN_BYTES) v = CFG_MIN_BYTES;
        if (v > 262144) v = 262144;
        cfg_bytes = v & ~32'd3;
    endfunction

    function automatic t_out predict_result(t_in x);
        t_out r;
        int unsigned need, sw, base, nxt, left;
        r = '0;
        case (x.mode)
            MODE_ALLOC: begin
                need = (HDR_BYTES + x.request_bytes + 3) & ~32'd3;
                if (need > live_words * 4) begin
                    r.status = ST_TOO_LARGE;
                end else begin
                    sw = need >> 2;
                    if (rover_at_end || rover > live_words - sw) begin
                        if (!rover_at_end) r.wrapped_now = 1'b1;
                        rover = 0;
                        rover_at_end = 1'b0;
                    end
                    base = rover;
                    drop_owner(base);
                    while (size_words[base] < sw) begin
                        nxt = base + size_words[base];
                        if (nxt >= live_words) break;
                        drop_owner(nxt);
                        size_words[base] += size_words[nxt];
                    end
                    left = (size_words[base] >= sw) ? size_words[base] - sw : 0;
                    if (left * 4 > SPLIT_MIN) begin
                        size_words[base + sw] = left;
                        owner_tag[base + sw] = 0;
                        size_words[base] = sw;
                        rover = base + sw;
                    end else begin
                        nxt = base + size_words[base];
                        if (nxt >= live_words) begin
                            rover_at_end = 1'b1;
                            rover = 0;
                        end else begin
                            rover = nxt;
                        end
                    end
                    owner_tag[base] = x.owner + 1;
                    owner_word[x.owner] = base;
                    owner_held[x.owner] = 1'b1;
                    if (wrapped_flag) begin
                        if (r.wrapped_now || (!rover_at_end &&
                                (first_at_end || rover >= first_rover)))
                            thrash_flag = 1'b1;
                    end else if (r.wrapped_now) begin
                        wrapped_flag = 1'b1;
                    end
                    r.block_offset = base * 4;
                end
            end
            MODE_LOOKUP: begin
                if (owner_held[x.owner]) r.block_offset = owner_word[x.owner] * 4;
                else r.status = ST_NOT_CACHED;
            end
            MODE_FLUSH: reset_cache();
            default: begin
                first_rover = rover;
                first_at_end = rover_at_end;
                wrapped_flag = 1'b0;
                thrash_flag = 1'b0;
            end
        endcase
        r.thrashing = thrash_flag;
        return r;
    endfunction

    // Sender: optional gap, then hold the request until it is taken.
    task automatic send_request(t_in x, bit typed = 1'b0, t_out want = '0);
        t_out r;
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_in <= x;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
            @(negedge i_clk);
        end
        r = predict_result(x);
        pending_results.push_back(typed ? want : r);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_cache_bytes(logic [18:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        set_cache_bytes(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in random_request();
        t_in x;
        int r;
        r = $urandom_range(0, 99);
        x.mode = (r < 70) ? MODE_ALLOC : (r < 92) ? MODE_LOOKUP :
                 (r < 99) ? MODE_FRAME : MODE_FLUSH;
        x.owner = ($urandom_range(0, 99) < 80) ? 12'($urandom_range(0, 31)) :
                  12'($urandom);
        r = $urandom_range(0, 99);
        if (r < 75) x.request_bytes = 19'($urandom_range(0, 1500));
        else if (r < 90) x.request_bytes = 19'($urandom_range(0, cfg_bytes));
        else if (r < 95) x.request_bytes = 19'($urandom);
        else x.request_bytes = 19'($urandom_range(cfg_bytes - 70, cfg_bytes));
        return x;
    endfunction

    function automatic t_row row(logic [1:0] m, int o, int b, bit typed = 0,
                                 logic [1:0] st = ST_OK, int off = 0,
                                 bit wr = 0, bit th = 0);
        row.req = '{mode: m, owner: o[11:0], request_bytes: b[18:0]};
        row.typed = typed;
        row.want = '{status: st, block_offset: off[17:0], wrapped_now: wr, thrashing: th};
    endfunction

    // Result channel: random stall, or a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result %p with no request pending", $time, o_out);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status)
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out.status);
                if (o_out.block_offset !== want.block_offset)
                    $display("%0t: block_offset expected %0d actual %0d",
                             $time, want.block_offset, o_out.block_offset);
                if (o_out.wrapped_now !== want.wrapped_now)
                    $display("%0t: wrapped_now expected %0d actual %0d",
                             $time, want.wrapped_now, o_out.wrapped_now);
                if (o_out.thrashing !== want.thrashing)
                    $display("%0t: thrashing expected %0d actual %0d",
                             $time, want.thrashing, o_out.thrashing);
                if (o_out !== want) errors++;
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** rover_surface_cache_allocator: FAILED **");
            $finish;
        end
    end

    initial begin
        t_row directed[$];
        int   cache_sizes[6] = '{262144, 0, 1027, 4096, 'h7FFFF, 65536};
        int   gaps[4] = '{0, 51, 0, 14};
        int   stalls[4] = '{0, 0, 51, 14};

        cfg_bytes = 262144;
        foreach (size_words[i]) begin
            size_words[i] = 0;
            owner_tag[i] = 0;
        end
        foreach (owner_word[i]) owner_word[i] = 0;
        reset_cache();
        first_rover = 0;
        first_at_end = 0;
        wrapped_flag = 0;
        thrash_flag = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(row(MODE_LOOKUP, 5, 0, 1, ST_NOT_CACHED));
        directed.push_back(row(MODE_ALLOC, 0, 0, 1, ST_OK, 0));
        directed.push_back(row(MODE_LOOKUP, 0, 0, 1, ST_OK, 0));
        directed.push_back(row(MODE_ALLOC, 4095, 'h7FFFF, 1, ST_TOO_LARGE));
        directed.push_back(row(MODE_ALLOC, 4095, 262081, 1, ST_TOO_LARGE));
        directed.push_back(row(MODE_ALLOC, 4095, 262080));
        directed.push_back(row(MODE_LOOKUP, 0, 0));
        directed.push_back(row(MODE_LOOKUP, 4095, 0));
        directed.push_back(row(MODE_ALLOC, 1, 192));
        directed.push_back(row(MODE_ALLOC, 2, 256));
        directed.push_back(row(MODE_FRAME, 'hAAA, 'h55555, 1, ST_OK, 0));
        directed.push_back(row(MODE_ALLOC, 3, 131000));
        directed.push_back(row(MODE_ALLOC, 4, 131000));
        directed.push_back(row(MODE_ALLOC, 5, 131000));
        directed.push_back(row(MODE_ALLOC, 6, 1000));
        directed.push_back(row(MODE_LOOKUP, 4095, 'h2AAAA));
        directed.push_back(row(MODE_LOOKUP, 3, 0));
        directed.push_back(row(MODE_FLUSH, 0, 0));
        directed.push_back(row(MODE_LOOKUP, 6, 0));
        directed.push_back(row(MODE_FRAME, 0, 0, 1, ST_OK, 0));
        foreach (directed[i])
            send_request(directed[i].req, directed[i].typed, directed[i].want);

        foreach (cache_sizes[p]) begin
            drain_results();
            write_cache_bytes(19'(cache_sizes[p]));
            send_request('{mode: MODE_FLUSH, owner: '0, request_bytes: '0});
            send_gap_pct = gaps[p % 4];
            stall_pct = stalls[p % 4];
            if (p == 0) hold_cycles <= 600;
            for (int n = 0; n < 240; n++) begin
                // One pause mid-run until every result is back.
                if (p == 1 && n == 120) drain_results();
                send_request(random_request());
            end
        end

        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("** rover_surface_cache_allocator: PASSED **");
        end else begin
            $display("** rover_surface_cache_allocator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rsca_pkg.sv
rtl/core/rsca_ram.sv
rtl/core/rover_surface_cache_allocator.sv
test/rover_surface_cache_allocator_tb.sv
